// ----- hw/rtl/rfds_pkg.sv -----
// Shared types and constants for the read-first DRAM transaction scheduler.
// Used by rfds_queue and read_first_dram_txn_scheduler; depends on nothing.
package rfds_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int BANK_COUNT  = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int BANK_W      = 4;
	localparam int ROW_W       = 16;
	localparam int SEQ_W       = 16;
	localparam int MARK_W      = 6;

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_TICK = 2'd1,
		REQ_ROW  = 2'd2,
		REQ_NOP  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_HIGH_MARK = 2'd0,
		REG_LOW_MARK  = 2'd1,
		REG_POLICY    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]       addr;
		logic [SEQ_W-1:0]  seq;
		logic [BANK_W-1:0] bank;
		logic [ROW_W-1:0]  row;
		logic [7:0]        tag;
	} entry_t;

	typedef entry_t [QUEUE_DEPTH-1:0] entry_arr_t;

	// a came before b, arrival numbers compared modulo 2^SEQ_W
	function automatic logic is_older(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = b - a;
		return (d != '0) && !d[SEQ_W-1];
	endfunction

endpackage

// ----- hw/rtl/rfds_queue.sv -----
// One arrival-ordered transaction queue: append at the tail, remove at any
// position by shifting younger entries down. Depends on rfds_pkg.
module rfds_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  rfds_pkg::entry_t         push_entry,
	input  logic                     remove,
	input  logic [rfds_pkg::IDX_W-1:0] remove_idx,
	output rfds_pkg::entry_arr_t     entries,
	output logic [rfds_pkg::CNT_W-1:0] count
);
	import rfds_pkg::*;

	entry_arr_t        entries_q;
	logic [CNT_W-1:0]  count_q;

	for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_slot
		always_ff @(posedge clk) begin
			if (remove && (IDX_W'(gi) >= remove_idx)) begin
				if (gi < QUEUE_DEPTH - 1) begin
					entries_q[gi] <= entries_q[(gi + 1) % QUEUE_DEPTH];
				end
			end else if (push && (count_q == CNT_W'(gi))) begin
				entries_q[gi] <= push_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (remove) begin
			count_q <= count_q - 1'b1;
		end else if (push) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign entries = entries_q;
	assign count   = count_q;

endmodule

// ----- hw/rtl/read_first_dram_txn_scheduler.sv -----
// Top level of the read-first DRAM transaction scheduler: stream ports,
// register port, scan sequencer. Depends on rfds_pkg and rfds_queue.
//
// Usage: each input transaction on s_t* carries one request (s_tuser is the
// request type). Every request yields exactly one result on m_t*.
// Push and bank-row requests finish in the accepting cycle; the result is
// presented the cycle after. A tick scans the preferred queue one entry per
// cycle, then the other queue if nothing was found, then removes the chosen
// entry in the remove state. The single candidate compare unit walks the
// queue entries; FCFS mode looks at the queue heads only.
// s_tready is low while a tick is in progress and while a result is held
// but not taken; a stalled receiver holds the result in the output register
// and blocks new requests until it is taken.
// Reset (arst_n low) empties both queues, closes all banks, selects
// read-first mode and loads the register defaults (high mark 32, low mark 6,
// row-hit-first policy). Registers are to be written through the APB-style
// port only while no request is in flight; the block itself does not enforce this.
module read_first_dram_txn_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// is_read[0], address[32:1], bank[36:33], row[52:37], tag[60:53],
	// bank_ready[76:61], row_open[77], zero fill [79:78]
	input  logic [79:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], issued[1], issued_is_read[2], issued_tag[10:3],
	// issued_address[42:11], zero fill [47:43]
	output logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rfds_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REMOVE} state_t;

	state_t              state_q;
	logic                cur_rd_q, tried_q, found_q, drain_q;
	logic [CNT_W-1:0]    scan_q;
	logic [IDX_W-1:0]    first_q, idx_q;
	logic [SEQ_W-1:0]    arrival_q;
	logic [15:0]         ready_q;
	logic [MARK_W-1:0]   high_mark_q, low_mark_q;
	logic                policy_q;
	logic [ROW_W:0]      bank_rows_q [BANK_COUNT];
	logic                out_valid_q;
	logic [47:0]         out_data_q;

	// input fields
	logic                in_is_read, in_row_open;
	logic [31:0]         in_address;
	logic [BANK_W-1:0]   in_bank;
	logic [ROW_W-1:0]    in_row;
	logic [7:0]          in_tag;
	logic [15:0]         in_ready;
	req_t                in_req;

	assign in_is_read  = s_tdata[0];
	assign in_address  = s_tdata[32:1];
	assign in_bank     = s_tdata[36:33];
	assign in_row      = s_tdata[52:37];
	assign in_tag      = s_tdata[60:53];
	assign in_ready    = s_tdata[76:61];
	assign in_row_open = s_tdata[77];
	assign in_req      = req_t'(s_tuser);

	logic in_fire;
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign in_fire  = s_tvalid && s_tready;

	// queues
	entry_arr_t        rd_entries, wr_entries;
	logic [CNT_W-1:0]  rd_count, wr_count;
	logic              rd_push, wr_push, rd_remove, wr_remove;
	entry_t            push_entry;
	logic              push_ok;

	assign push_entry = '{addr: in_address, seq: arrival_q, bank: in_bank,
		row: in_row, tag: in_tag};
	assign push_ok   = in_is_read ? (rd_count < CNT_W'(QUEUE_DEPTH))
	                              : (wr_count < CNT_W'(QUEUE_DEPTH));
	assign rd_push   = in_fire && (in_req == REQ_PUSH) && in_is_read && push_ok;
	assign wr_push   = in_fire && (in_req == REQ_PUSH) && !in_is_read && push_ok;
	assign rd_remove = (state_q == ST_REMOVE) && cur_rd_q;
	assign wr_remove = (state_q == ST_REMOVE) && !cur_rd_q;

	rfds_queue u_rd_queue (
		.clk, .arst_n, .push(rd_push), .push_entry, .remove(rd_remove),
		.remove_idx(idx_q), .entries(rd_entries), .count(rd_count)
	);

	rfds_queue u_wr_queue (
		.clk, .arst_n, .push(wr_push), .push_entry, .remove(wr_remove),
		.remove_idx(idx_q), .entries(wr_entries), .count(wr_count)
	);

	// candidate compare unit
	logic [IDX_W-1:0]  cand_idx;
	entry_t            cand;
	entry_arr_t        oth_entries;
	logic [CNT_W-1:0]  oth_count, cur_count, scan_limit;
	logic [QUEUE_DEPTH-1:0] dep_hit;
	logic              cand_elig, cand_row_hit;
	logic [ROW_W:0]    cand_bank_row;

	assign cand_idx    = (state_q == ST_REMOVE) ? idx_q : scan_q[IDX_W-1:0];
	assign cand        = cur_rd_q ? rd_entries[cand_idx] : wr_entries[cand_idx];
	assign oth_entries = cur_rd_q ? wr_entries : rd_entries;
	assign oth_count   = cur_rd_q ? wr_count : rd_count;
	assign cur_count   = cur_rd_q ? rd_count : wr_count;
	assign scan_limit  = policy_q ? cur_count : CNT_W'(cur_count != '0);

	always_comb begin
		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			dep_hit[j] = (CNT_W'(j) < oth_count) && (oth_entries[j].addr == cand.addr)
				&& is_older(oth_entries[j].seq, cand.seq);
		end
	end

	assign cand_bank_row = bank_rows_q[cand.bank];
	assign cand_elig     = ready_q[cand.bank] && (dep_hit == '0);
	assign cand_row_hit  = cand_bank_row[ROW_W] && (cand_bank_row[ROW_W-1:0] == cand.row);

	logic drain_next;
	always_comb begin
		if ((CNT_W'(wr_count) >= CNT_W'(high_mark_q)) || (rd_count == '0)) begin
			drain_next = 1'b1;
		end else if (CNT_W'(wr_count) < CNT_W'(low_mark_q)) begin
			drain_next = 1'b0;
		end else begin
			drain_next = drain_q;
		end
	end

	// a result is loaded into the output register this cycle
	logic result_set;
	assign result_set = ((state_q == ST_IDLE) && in_fire && (in_req != REQ_TICK))
		|| ((state_q == ST_SCAN) && (scan_q >= scan_limit) && !found_q && tried_q)
		|| (state_q == ST_REMOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_set) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_rd_q    <= 1'b1;
			tried_q     <= 1'b0;
			found_q     <= 1'b0;
			drain_q     <= 1'b0;
			scan_q      <= '0;
			first_q     <= '0;
			idx_q       <= '0;
			arrival_q   <= '0;
			out_data_q  <= '0;
			for (int b = 0; b < BANK_COUNT; b++) begin
				bank_rows_q[b] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_req)
							REQ_PUSH: begin
								out_data_q  <= {47'd0, push_ok};
								if (push_ok) begin
									arrival_q <= arrival_q + 1'b1;
								end
							end
							REQ_TICK: begin
								drain_q  <= drain_next;
								cur_rd_q <= !drain_next;
								tried_q  <= 1'b0;
								found_q  <= 1'b0;
								scan_q   <= '0;
								state_q  <= ST_SCAN;
							end
							REQ_ROW: begin
								bank_rows_q[in_bank] <= {in_row_open, in_row};
								out_data_q  <= '0;
							end
							REQ_NOP: begin
								out_data_q  <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_q >= scan_limit) begin
						if (found_q) begin
							idx_q   <= first_q;
							state_q <= ST_REMOVE;
						end else if (!tried_q) begin
							// fall back to the other queue
							cur_rd_q <= !cur_rd_q;
							tried_q  <= 1'b1;
							scan_q   <= '0;
						end else begin
							out_data_q  <= '0;
							state_q     <= ST_IDLE;
						end
					end else begin
						if (cand_elig && cand_row_hit) begin
							idx_q   <= scan_q[IDX_W-1:0];
							state_q <= ST_REMOVE;
						end else if (cand_elig && !found_q) begin
							found_q <= 1'b1;
							first_q <= scan_q[IDX_W-1:0];
						end
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_REMOVE: begin
					out_data_q  <= {5'd0, cand.addr, cand.tag, cur_rd_q, 1'b1, 1'b0};
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_req == REQ_TICK)) begin
			ready_q <= in_ready;
		end
	end

	// register port
	reg_idx_t reg_idx;
	logic     cfg_wr;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_mark_q <= MARK_W'(32);
			low_mark_q  <= MARK_W'(6);
			policy_q    <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_HIGH_MARK: high_mark_q <= pwdata[MARK_W-1:0];
				REG_LOW_MARK:  low_mark_q  <= pwdata[MARK_W-1:0];
				REG_POLICY:    policy_q    <= pwdata[0];
				REG_NONE:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HIGH_MARK: prdata = {26'd0, high_mark_q};
			REG_LOW_MARK:  prdata = {26'd0, low_mark_q};
			REG_POLICY:    prdata = {31'd0, policy_q};
			REG_NONE:      prdata = '0;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
